// File: hw/rtl/lli_pkg.sv
// Line pair intersection: shared constants, result kind codes and the
// tag that rides along with each item. No dependencies.
package lli_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int OUT_BITS       = 48;
   // quotient bits resolved per divider stage
   localparam int STEP_BITS      = 4;

   // divider lanes: x, y and the position along the first line
   localparam int N_LANES = 3;
   localparam int LANE_X  = 0;
   localparam int LANE_Y  = 1;
   localparam int LANE_T  = 2;

   typedef enum logic [2:0] {
      KIND_GENERAL   = 3'd0,
      KIND_A_VERT    = 3'd1,
      KIND_B_VERT    = 3'd2,
      KIND_BOTH_VERT = 3'd3,
      KIND_SAME      = 3'd4,
      KIND_NONE      = 3'd5
   } kind_type;

   typedef struct packed {
      logic     found;
      kind_type kind;
   } tag_type;

endpackage

// File: hw/rtl/lli_if.sv
// Line pair intersection: request and response channel interfaces.
// Depends on lli_pkg.
interface lli_req_if #(parameter int COORD_BITS = lli_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_x1;
   logic signed [COORD_BITS-1:0] a_y1;
   logic signed [COORD_BITS-1:0] a_x2;
   logic signed [COORD_BITS-1:0] a_y2;
   logic signed [COORD_BITS-1:0] b_x1;
   logic signed [COORD_BITS-1:0] b_y1;
   logic signed [COORD_BITS-1:0] b_x2;
   logic signed [COORD_BITS-1:0] b_y2;

   modport source (output valid, a_x1, a_y1, a_x2, a_y2, b_x1, b_y1, b_x2, b_y2,
                   input ready);
   modport sink   (input valid, a_x1, a_y1, a_x2, a_y2, b_x1, b_y1, b_x2, b_y2,
                   output ready);
endinterface

interface lli_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 found;
   logic [2:0]                           meet_kind;
   logic signed [lli_pkg::OUT_BITS-1:0]  meet_x;
   logic signed [lli_pkg::OUT_BITS-1:0]  meet_y;
   logic signed [lli_pkg::OUT_BITS-1:0]  param_t;

   modport source (output valid, found, meet_kind, meet_x, meet_y, param_t, input ready);
   modport sink   (input valid, found, meet_kind, meet_x, meet_y, param_t, output ready);
endinterface

// File: hw/rtl/line_line_intersection_unit.sv
// Line pair intersection unit. A request passes through 5 front-end stages and then
// 14 divider stages (setup, 12 quotient stages of 4 bits each, saturation) on its way
// to the response. Throughput one pair per cycle while the response side is ready;
// every stage advances when its successor frees up, so bubbles close under stall.
// Synchronous active-high reset clears all valid bits; no state beyond that.
module line_line_intersection_unit #(
   parameter int COORD_BITS = lli_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = lli_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lli_req_if.sink    req_chan,
   lli_rsp_if.source  rsp_chan
);
   import lli_pkg::*;

   localparam int NW = 3*COORD_BITS + 5;
   localparam int DW = 2*COORD_BITS + 3;

   logic                 fe_valid, fe_ready;
   logic signed [NW-1:0] fe_num [N_LANES];
   logic signed [DW-1:0] fe_den [N_LANES];
   tag_type              fe_tag;
   logic signed [OUT_BITS-1:0] dv_res [N_LANES];
   tag_type              dv_tag;

   lli_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .out_valid (fe_valid),
      .out_ready (fe_ready),
      .out_num   (fe_num),
      .out_den   (fe_den),
      .out_tag   (fe_tag)
   );

   lli_div #(.NUM_W(NW), .DEN_W(DW), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_num    (fe_num),
      .in_den    (fe_den),
      .in_tag    (fe_tag),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_res   (dv_res),
      .out_tag   (dv_tag)
   );

   assign rsp_chan.found     = dv_tag.found;
   assign rsp_chan.meet_kind = dv_tag.kind;
   assign rsp_chan.meet_x    = dv_res[LANE_X];
   assign rsp_chan.meet_y    = dv_res[LANE_Y];
   assign rsp_chan.param_t   = dv_res[LANE_T];

`ifndef SYNTH
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.found |->
         rsp_chan.meet_x == '0 && rsp_chan.meet_y == '0 && rsp_chan.param_t == '0 &&
         rsp_chan.meet_kind == KIND_NONE)
      else $error("no-intersection result carries nonzero fields");
   a_found_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.found |-> rsp_chan.meet_kind != KIND_NONE)
      else $error("found result with kind none");
   a_same_t: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.meet_kind == KIND_SAME |-> rsp_chan.param_t == '0)
      else $error("same-line result with nonzero position");
`endif

endmodule

// File: hw/rtl/lli_front.sv
// Line pair intersection front end: differences, cross products, case
// selection. Five register stages; emits numerator/denominator per lane. Uses lli_pkg.
module lli_front #(
   parameter int COORD_BITS = lli_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   lli_req_if.sink                       req,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [3*COORD_BITS+4:0] out_num [lli_pkg::N_LANES],
   output logic signed [2*COORD_BITS+2:0] out_den [lli_pkg::N_LANES],
   output lli_pkg::tag_type              out_tag
);
   import lli_pkg::*;

   localparam int CW   = COORD_BITS;
   localparam int DF   = CW + 1;
   localparam int PW   = 2*CW + 2;
   localparam int SW   = PW + 1;
   localparam int PRW  = SW + DF;
   localparam int NW   = 3*CW + 5;
   localparam int DW   = SW;
   localparam int T3   = CW + 3;
   localparam int NSTG = 5;

   typedef struct packed {
      logic adx0;
      logic bdx0;
      logic xeq;
   } flg_type;

   logic [NSTG-1:0] vld_ff, vld_in, en;

   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || out_ready;
      for (int k = NSTG-2; k >= 0; k--) en[k] = !vld_ff[k] || en[k+1];
      vld_in[0] = en[0] ? req.valid : vld_ff[0];
      for (int k = 1; k < NSTG; k++) vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
   end

   assign req.ready = en[0];
   assign out_valid = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   // ---- stage 1: differences
   logic signed [CW-1:0] s1_ax1_ff, s1_ay1_ff, s1_bx1_ff, s1_by1_ff, s1_amax_ff, s1_bmin_ff;
   logic signed [CW-1:0] s1_amax_in, s1_bmin_in;
   logic signed [DF-1:0] s1_adx_ff, s1_ady_ff, s1_bdx_ff, s1_bdy_ff;
   logic signed [DF-1:0] s1_e1_ff, s1_e2_ff, s1_e3_ff;
   logic signed [DF-1:0] s1_adx_in, s1_ady_in, s1_bdx_in, s1_bdy_in;
   logic signed [DF-1:0] s1_e1_in, s1_e2_in, s1_e3_in;
   flg_type              s1_flg_ff, s1_flg_in;

   assign s1_adx_in = DF'(req.a_x2) - DF'(req.a_x1);
   assign s1_ady_in = DF'(req.a_y2) - DF'(req.a_y1);
   assign s1_bdx_in = DF'(req.b_x2) - DF'(req.b_x1);
   assign s1_bdy_in = DF'(req.b_y2) - DF'(req.b_y1);
   assign s1_e1_in  = DF'(req.a_x1) - DF'(req.b_x1);
   assign s1_e2_in  = DF'(req.b_y1) - DF'(req.a_y1);
   assign s1_e3_in  = DF'(req.b_x1) - DF'(req.a_x1);
   assign s1_amax_in = (req.a_y1 >= req.a_y2) ? req.a_y1 : req.a_y2;
   assign s1_bmin_in = (req.b_y1 >= req.b_y2) ? req.b_y2 : req.b_y1;
   assign s1_flg_in.adx0 = (req.a_x2 == req.a_x1);
   assign s1_flg_in.bdx0 = (req.b_x2 == req.b_x1);
   assign s1_flg_in.xeq  = (req.b_x1 == req.a_x1);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ax1_ff  <= req.a_x1;
         s1_ay1_ff  <= req.a_y1;
         s1_bx1_ff  <= req.b_x1;
         s1_by1_ff  <= req.b_y1;
         s1_amax_ff <= s1_amax_in;
         s1_bmin_ff <= s1_bmin_in;
         s1_adx_ff  <= s1_adx_in;
         s1_ady_ff  <= s1_ady_in;
         s1_bdx_ff  <= s1_bdx_in;
         s1_bdy_ff  <= s1_bdy_in;
         s1_e1_ff   <= s1_e1_in;
         s1_e2_ff   <= s1_e2_in;
         s1_e3_ff   <= s1_e3_in;
         s1_flg_ff  <= s1_flg_in;
      end
   end

   // ---- stage 2: first products
   logic signed [PW-1:0] s2_ayadx_ff, s2_adyax_ff, s2_bybdx_ff, s2_bdybx_ff, s2_adybdx_ff;
   logic signed [PW-1:0] s2_bdyadx_ff, s2_bdye1_ff, s2_adye3_ff, s2_e2bdx_ff, s2_e3bdy_ff;
   logic signed [PW-1:0] s2_ayadx_in, s2_adyax_in, s2_bybdx_in, s2_bdybx_in, s2_adybdx_in;
   logic signed [PW-1:0] s2_bdyadx_in, s2_bdye1_in, s2_adye3_in, s2_e2bdx_in, s2_e3bdy_in;
   logic signed [DF-1:0] s2_k3my_ff, s2_k3my_in;
   logic signed [T3-1:0] s2_k3t_ff, s2_k3t_in;
   logic signed [CW-1:0] s2_ax1_ff, s2_ay1_ff, s2_bx1_ff;
   logic signed [DF-1:0] s2_adx_ff, s2_ady_ff, s2_bdx_ff, s2_bdy_ff, s2_e3_ff;
   flg_type              s2_flg_ff;

   assign s2_ayadx_in  = PW'(s1_ay1_ff) * PW'(s1_adx_ff);
   assign s2_adyax_in  = PW'(s1_ady_ff) * PW'(s1_ax1_ff);
   assign s2_bybdx_in  = PW'(s1_by1_ff) * PW'(s1_bdx_ff);
   assign s2_bdybx_in  = PW'(s1_bdy_ff) * PW'(s1_bx1_ff);
   assign s2_adybdx_in = PW'(s1_ady_ff) * PW'(s1_bdx_ff);
   assign s2_bdyadx_in = PW'(s1_bdy_ff) * PW'(s1_adx_ff);
   assign s2_bdye1_in  = PW'(s1_bdy_ff) * PW'(s1_e1_ff);
   assign s2_adye3_in  = PW'(s1_ady_ff) * PW'(s1_e3_ff);
   assign s2_e2bdx_in  = PW'(s1_e2_ff)  * PW'(s1_bdx_ff);
   assign s2_e3bdy_in  = PW'(s1_e3_ff)  * PW'(s1_bdy_ff);
   assign s2_k3my_in   = DF'(s1_amax_ff) + DF'(s1_bmin_ff);
   assign s2_k3t_in    = T3'(s1_amax_ff) + T3'(s1_bmin_ff) - (T3'(s1_ay1_ff) <<< 1);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_ayadx_ff  <= s2_ayadx_in;
         s2_adyax_ff  <= s2_adyax_in;
         s2_bybdx_ff  <= s2_bybdx_in;
         s2_bdybx_ff  <= s2_bdybx_in;
         s2_adybdx_ff <= s2_adybdx_in;
         s2_bdyadx_ff <= s2_bdyadx_in;
         s2_bdye1_ff  <= s2_bdye1_in;
         s2_adye3_ff  <= s2_adye3_in;
         s2_e2bdx_ff  <= s2_e2bdx_in;
         s2_e3bdy_ff  <= s2_e3bdy_in;
         s2_k3my_ff   <= s2_k3my_in;
         s2_k3t_ff    <= s2_k3t_in;
         s2_ax1_ff    <= s1_ax1_ff;
         s2_ay1_ff    <= s1_ay1_ff;
         s2_bx1_ff    <= s1_bx1_ff;
         s2_adx_ff    <= s1_adx_ff;
         s2_ady_ff    <= s1_ady_ff;
         s2_bdx_ff    <= s1_bdx_ff;
         s2_bdy_ff    <= s1_bdy_ff;
         s2_e3_ff     <= s1_e3_ff;
         s2_flg_ff    <= s1_flg_ff;
      end
   end

   // ---- stage 3: intercept terms, determinant, side-case numerators
   logic signed [SW-1:0] s3_ca_ff, s3_cb_ff, s3_d_ff, s3_k1my_ff, s3_k1t_ff, s3_k2my_ff, s3_tg_ff;
   logic signed [SW-1:0] s3_ca_in, s3_cb_in, s3_d_in, s3_k1my_in, s3_k1t_in, s3_k2my_in, s3_tg_in;
   logic signed [PW-1:0] s3_k1d_ff;
   logic signed [DF-1:0] s3_k3my_ff;
   logic signed [T3-1:0] s3_k3t_ff;
   logic signed [CW-1:0] s3_ax1_ff, s3_ay1_ff, s3_bx1_ff;
   logic signed [DF-1:0] s3_adx_ff, s3_ady_ff, s3_bdx_ff, s3_bdy_ff, s3_e3_ff;
   flg_type              s3_flg_ff;

   assign s3_ca_in   = SW'(s2_ayadx_ff) - SW'(s2_adyax_ff);
   assign s3_cb_in   = SW'(s2_bybdx_ff) - SW'(s2_bdybx_ff);
   assign s3_d_in    = SW'(s2_adybdx_ff) - SW'(s2_bdyadx_ff);
   assign s3_k1my_in = SW'(s2_bybdx_ff) + SW'(s2_bdye1_ff);
   assign s3_k1t_in  = SW'(s2_e2bdx_ff) + SW'(s2_bdye1_ff);
   assign s3_k2my_in = SW'(s2_ayadx_ff) + SW'(s2_adye3_ff);
   assign s3_tg_in   = SW'(s2_e2bdx_ff) - SW'(s2_e3bdy_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_ca_ff   <= s3_ca_in;
         s3_cb_ff   <= s3_cb_in;
         s3_d_ff    <= s3_d_in;
         s3_k1my_ff <= s3_k1my_in;
         s3_k1t_ff  <= s3_k1t_in;
         s3_k2my_ff <= s3_k2my_in;
         s3_tg_ff   <= s3_tg_in;
         s3_k1d_ff  <= s2_adybdx_ff;
         s3_k3my_ff <= s2_k3my_ff;
         s3_k3t_ff  <= s2_k3t_ff;
         s3_ax1_ff  <= s2_ax1_ff;
         s3_ay1_ff  <= s2_ay1_ff;
         s3_bx1_ff  <= s2_bx1_ff;
         s3_adx_ff  <= s2_adx_ff;
         s3_ady_ff  <= s2_ady_ff;
         s3_bdx_ff  <= s2_bdx_ff;
         s3_bdy_ff  <= s2_bdy_ff;
         s3_e3_ff   <= s2_e3_ff;
         s3_flg_ff  <= s2_flg_ff;
      end
   end

   // ---- stage 4: second products for the general crossing
   logic signed [PRW-1:0] s4_cbadx_ff, s4_cabdx_ff, s4_adycb_ff, s4_bdyca_ff;
   logic signed [PRW-1:0] s4_cbadx_in, s4_cabdx_in, s4_adycb_in, s4_bdyca_in;
   logic                  s4_dnz_ff, s4_dnz_in;
   logic signed [SW-1:0]  s4_d_ff, s4_k1my_ff, s4_k1t_ff, s4_k2my_ff, s4_tg_ff;
   logic signed [PW-1:0]  s4_k1d_ff;
   logic signed [DF-1:0]  s4_k3my_ff;
   logic signed [T3-1:0]  s4_k3t_ff;
   logic signed [CW-1:0]  s4_ax1_ff, s4_ay1_ff, s4_bx1_ff;
   logic signed [DF-1:0]  s4_adx_ff, s4_ady_ff, s4_bdx_ff, s4_e3_ff;
   flg_type               s4_flg_ff;

   assign s4_cbadx_in = PRW'(s3_cb_ff)  * PRW'(s3_adx_ff);
   assign s4_cabdx_in = PRW'(s3_ca_ff)  * PRW'(s3_bdx_ff);
   assign s4_adycb_in = PRW'(s3_ady_ff) * PRW'(s3_cb_ff);
   assign s4_bdyca_in = PRW'(s3_bdy_ff) * PRW'(s3_ca_ff);
   assign s4_dnz_in   = (s3_d_ff != '0);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_cbadx_ff <= s4_cbadx_in;
         s4_cabdx_ff <= s4_cabdx_in;
         s4_adycb_ff <= s4_adycb_in;
         s4_bdyca_ff <= s4_bdyca_in;
         s4_dnz_ff   <= s4_dnz_in;
         s4_d_ff     <= s3_d_ff;
         s4_k1my_ff  <= s3_k1my_ff;
         s4_k1t_ff   <= s3_k1t_ff;
         s4_k2my_ff  <= s3_k2my_ff;
         s4_tg_ff    <= s3_tg_ff;
         s4_k1d_ff   <= s3_k1d_ff;
         s4_k3my_ff  <= s3_k3my_ff;
         s4_k3t_ff   <= s3_k3t_ff;
         s4_ax1_ff   <= s3_ax1_ff;
         s4_ay1_ff   <= s3_ay1_ff;
         s4_bx1_ff   <= s3_bx1_ff;
         s4_adx_ff   <= s3_adx_ff;
         s4_ady_ff   <= s3_ady_ff;
         s4_bdx_ff   <= s3_bdx_ff;
         s4_e3_ff    <= s3_e3_ff;
         s4_flg_ff   <= s3_flg_ff;
      end
   end

   // ---- stage 5: case selection; a zero denominator makes the divider give 0
   logic signed [NW-1:0] s5_mxn, s5_myn;
   logic signed [NW-1:0] s5_num_ff [N_LANES];
   logic signed [NW-1:0] s5_num_in [N_LANES];
   logic signed [DW-1:0] s5_den_ff [N_LANES];
   logic signed [DW-1:0] s5_den_in [N_LANES];
   tag_type              s5_tag_ff, s5_tag_in;

   assign s5_mxn = NW'(s4_cbadx_ff) - NW'(s4_cabdx_ff);
   assign s5_myn = NW'(s4_adycb_ff) - NW'(s4_bdyca_ff);

   always_comb begin
      for (int i = 0; i < N_LANES; i++) begin
         s5_num_in[i] = '0;
         s5_den_in[i] = '0;
      end
      s5_tag_in.found = 1'b0;
      s5_tag_in.kind  = KIND_NONE;
      if (s4_flg_ff.adx0) begin
         if (s4_flg_ff.bdx0) begin
            if (s4_flg_ff.xeq) begin
               s5_tag_in.found   = 1'b1;
               s5_tag_in.kind    = KIND_BOTH_VERT;
               s5_num_in[LANE_X] = NW'(s4_ax1_ff);
               s5_den_in[LANE_X] = DW'(1);
               s5_num_in[LANE_Y] = NW'(s4_k3my_ff);
               s5_den_in[LANE_Y] = DW'(2);
               s5_num_in[LANE_T] = NW'(s4_k3t_ff);
               s5_den_in[LANE_T] = DW'(s4_ady_ff) <<< 1;
            end
         end else begin
            s5_tag_in.found   = 1'b1;
            s5_tag_in.kind    = KIND_A_VERT;
            s5_num_in[LANE_X] = NW'(s4_ax1_ff);
            s5_den_in[LANE_X] = DW'(1);
            s5_num_in[LANE_Y] = NW'(s4_k1my_ff);
            s5_den_in[LANE_Y] = DW'(s4_bdx_ff);
            s5_num_in[LANE_T] = NW'(s4_k1t_ff);
            s5_den_in[LANE_T] = DW'(s4_k1d_ff);
         end
      end else if (s4_flg_ff.bdx0) begin
         s5_tag_in.found   = 1'b1;
         s5_tag_in.kind    = KIND_B_VERT;
         s5_num_in[LANE_X] = NW'(s4_bx1_ff);
         s5_den_in[LANE_X] = DW'(1);
         s5_num_in[LANE_Y] = NW'(s4_k2my_ff);
         s5_den_in[LANE_Y] = DW'(s4_adx_ff);
         s5_num_in[LANE_T] = NW'(s4_e3_ff);
         s5_den_in[LANE_T] = DW'(s4_adx_ff);
      end else if (s4_dnz_ff) begin
         s5_tag_in.found   = 1'b1;
         s5_tag_in.kind    = KIND_GENERAL;
         s5_num_in[LANE_X] = s5_mxn;
         s5_den_in[LANE_X] = s4_d_ff;
         s5_num_in[LANE_Y] = s5_myn;
         s5_den_in[LANE_Y] = s4_d_ff;
         s5_num_in[LANE_T] = NW'(s4_tg_ff);
         s5_den_in[LANE_T] = s4_d_ff;
      end else if (s5_mxn == '0) begin
         // parallel with equal intercepts
         s5_tag_in.found   = 1'b1;
         s5_tag_in.kind    = KIND_SAME;
         s5_num_in[LANE_X] = NW'(s4_ax1_ff);
         s5_den_in[LANE_X] = DW'(1);
         s5_num_in[LANE_Y] = NW'(s4_ay1_ff);
         s5_den_in[LANE_Y] = DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_num_ff <= s5_num_in;
         s5_den_ff <= s5_den_in;
         s5_tag_ff <= s5_tag_in;
      end
   end

   assign out_num = s5_num_ff;
   assign out_den = s5_den_ff;
   assign out_tag = s5_tag_ff;

endmodule

// File: hw/rtl/lli_div.sv
// Line pair intersection: three-lane pipelined restoring divider giving
// (num * 2^FRAC_BITS) / den, truncated toward zero, saturated. Uses lli_pkg.
module lli_div #(
   parameter int NUM_W     = 3*lli_pkg::COORD_BITS_DEF + 5,
   parameter int DEN_W     = 2*lli_pkg::COORD_BITS_DEF + 3,
   parameter int FRAC_BITS = lli_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [NUM_W-1:0]         in_num [lli_pkg::N_LANES],
   input  logic signed [DEN_W-1:0]         in_den [lli_pkg::N_LANES],
   input  lli_pkg::tag_type                in_tag,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [lli_pkg::OUT_BITS-1:0] out_res [lli_pkg::N_LANES],
   output lli_pkg::tag_type                out_tag
);
   import lli_pkg::*;

   localparam int OW  = OUT_BITS;
   localparam int SB  = STEP_BITS;
   localparam int NS  = OW / SB;
   localparam int XW  = (NUM_W + FRAC_BITS > OW) ? NUM_W + FRAC_BITS : OW + 1;
   localparam int HW  = XW - OW;
   localparam int CWD = (HW > DEN_W) ? HW : DEN_W;
   localparam int NV  = NS + 2;

   logic [NV-1:0] vld_ff, vld_in, en;

   always_comb begin
      en[NV-1] = !vld_ff[NV-1] || out_ready;
      for (int k = NV-2; k >= 0; k--) en[k] = !vld_ff[k] || en[k+1];
      vld_in[0] = en[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < NV; k++) vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NV-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   // stage 0 is the magnitude/overflow setup, stages 1..NS the quotient steps
   logic [DEN_W-1:0] rem_ff [NS+1][N_LANES];
   logic [DEN_W-1:0] rem_in [NS+1][N_LANES];
   logic [DEN_W-1:0] dmag_ff [NS+1][N_LANES];
   logic [DEN_W-1:0] dmag_in [NS+1][N_LANES];
   logic [OW-1:0]    bits_ff [NS+1][N_LANES];
   logic [OW-1:0]    bits_in [NS+1][N_LANES];
   logic [OW-1:0]    quo_ff [NS+1][N_LANES];
   logic [OW-1:0]    quo_in [NS+1][N_LANES];
   logic [N_LANES-1:0] neg_ff [NS+1];
   logic [N_LANES-1:0] neg_in [NS+1];
   logic [N_LANES-1:0] zro_ff [NS+1];
   logic [N_LANES-1:0] zro_in [NS+1];
   logic [N_LANES-1:0] ovf_ff [NS+1];
   logic [N_LANES-1:0] ovf_in [NS+1];
   tag_type          tag_ff [NS+1];
   tag_type          tag_in [NS+1];
   logic signed [OW-1:0] res_ff [N_LANES];
   logic signed [OW-1:0] res_in [N_LANES];
   tag_type          otag_ff;

   always_comb begin
      logic [NUM_W-1:0] an;
      logic [DEN_W-1:0] ad;
      logic [XW-1:0]    xs;
      logic [CWD-1:0]   hi;
      logic [DEN_W-1:0] r;
      logic [OW-1:0]    b;
      logic [OW-1:0]    q;
      logic [DEN_W:0]   r2;
      logic [OW-1:0]    qs;
      for (int l = 0; l < N_LANES; l++) begin
         an = in_num[l][NUM_W-1] ? NUM_W'(-in_num[l]) : NUM_W'(in_num[l]);
         ad = in_den[l][DEN_W-1] ? DEN_W'(-in_den[l]) : DEN_W'(in_den[l]);
         xs = XW'(an) << FRAC_BITS;
         hi = CWD'(xs[XW-1:OW]);
         rem_in[0][l]  = hi[DEN_W-1:0];
         dmag_in[0][l] = ad;
         bits_in[0][l] = xs[OW-1:0];
         quo_in[0][l]  = '0;
         neg_in[0][l]  = in_num[l][NUM_W-1] ^ in_den[l][DEN_W-1];
         zro_in[0][l]  = (ad == '0);
         ovf_in[0][l]  = (hi >= CWD'(ad));
      end
      tag_in[0] = in_tag;

      for (int k = 1; k <= NS; k++) begin
         for (int l = 0; l < N_LANES; l++) begin
            r = rem_ff[k-1][l];
            b = bits_ff[k-1][l];
            q = quo_ff[k-1][l];
            for (int j = 0; j < SB; j++) begin
               r2 = {r, b[OW-1]};
               b  = b << 1;
               if (r2 >= {1'b0, dmag_ff[k-1][l]}) begin
                  r2 = r2 - {1'b0, dmag_ff[k-1][l]};
                  q  = {q[OW-2:0], 1'b1};
               end else begin
                  q  = {q[OW-2:0], 1'b0};
               end
               r = r2[DEN_W-1:0];
            end
            rem_in[k][l]  = r;
            bits_in[k][l] = b;
            quo_in[k][l]  = q;
            dmag_in[k][l] = dmag_ff[k-1][l];
         end
         neg_in[k] = neg_ff[k-1];
         zro_in[k] = zro_ff[k-1];
         ovf_in[k] = ovf_ff[k-1];
         tag_in[k] = tag_ff[k-1];
      end

      // saturate to the signed output range, then apply the sign
      for (int l = 0; l < N_LANES; l++) begin
         q  = quo_ff[NS][l];
         qs = q;
         if (neg_ff[NS][l]) begin
            if (ovf_ff[NS][l] || (q[OW-1] && (q[OW-2:0] != '0))) qs = {1'b1, {(OW-1){1'b0}}};
         end else begin
            if (ovf_ff[NS][l] || q[OW-1]) qs = {1'b0, {(OW-1){1'b1}}};
         end
         if (zro_ff[NS][l])      res_in[l] = '0;
         else if (neg_ff[NS][l]) res_in[l] = -$signed(qs);
         else                    res_in[l] = $signed(qs);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NS; k++) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            dmag_ff[k] <= dmag_in[k];
            bits_ff[k] <= bits_in[k];
            quo_ff[k]  <= quo_in[k];
            neg_ff[k]  <= neg_in[k];
            zro_ff[k]  <= zro_in[k];
            ovf_ff[k]  <= ovf_in[k];
            tag_ff[k]  <= tag_in[k];
         end
      end
      if (en[NV-1]) begin
         res_ff  <= res_in;
         otag_ff <= tag_ff[NS];
      end
   end

   assign out_res = res_ff;
   assign out_tag = otag_ff;

`ifndef SYNTH
   // a zero denominator always yields a zero quotient
   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      en[NV-1] && vld_ff[NV-2] && zro_ff[NS][LANE_T] |=> res_ff[LANE_T] == '0)
      else $error("divider: zero denominator gave nonzero result");
   // stalled output holds its valid
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NV-1] && !out_ready |=> vld_ff[NV-1])
      else $error("divider: result dropped while stalled");
   // on lane X, a quotient with no sign flip never comes out negative
   a_sign: assert property (@(posedge clock) disable iff (reset)
      en[NV-1] && vld_ff[NV-2] && !neg_ff[NS][LANE_X] |=> !res_ff[LANE_X][OW-1])
      else $error("divider: positive quotient came out negative");
`endif

endmodule
